// File: hw/rtl/sma_pkg.sv
package sma_pkg;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_SUB   = 2'd1,
    KIND_SCALE = 2'd2,
    KIND_CMP   = 2'd3
  } kind_t;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  // 1000000 = 2^6 * 15625: shift off six bits, then divide by 15625
  localparam int          LOW_BITS    = 6;
  localparam logic [13:0] SUB_DIVISOR = 14'd15625;
  // floor(2^45 / 15625); the estimate is low by at most one
  localparam logic [31:0] RECIP       = 32'd2251799813;
  localparam int          RECIP_SHIFT = 45;

  // front stage result, one item
  typedef struct packed {
    kind_t        kind;
    logic         less;
    logic         equal;
    logic [64:0]  pp_lo;   // signed, a_seconds[31:0] * scale_count
    logic [63:0]  pp_hi;   // signed, a_seconds[63:32] * scale_count
    logic [64:0]  addsub;  // signed, a_seconds +/- b_seconds
    logic [50:0]  mag;     // magnitude of the microsecond total
    logic         neg;     // microsecond total is negative
  } front_t;

  // seconds path, aligned with the divider output
  typedef struct packed {
    kind_t        kind;
    logic         less;
    logic         equal;
    logic [97:0]  base;    // signed exact seconds before the carry
  } sec_t;

endpackage

// File: hw/rtl/sma_if.sv
interface sma_req_if;
  logic                 valid;
  logic                 ready;
  sma_pkg::kind_t       kind;
  logic signed [63:0]   a_seconds;
  logic        [19:0]   a_micro;
  logic signed [63:0]   b_seconds;
  logic        [19:0]   b_micro;
  logic signed [31:0]   scale_count;

  modport source (output valid, kind, a_seconds, a_micro, b_seconds, b_micro, scale_count,
                  input ready);
  modport sink (input valid, kind, a_seconds, a_micro, b_seconds, b_micro, scale_count,
                output ready);
endinterface

interface sma_rsp_if;
  logic                 valid;
  logic                 ready;
  logic signed [63:0]   res_seconds;
  logic        [19:0]   res_micro;
  logic                 is_less;
  logic                 is_equal;
  logic                 overflow;

  modport source (output valid, res_seconds, res_micro, is_less, is_equal, overflow,
                  input ready);
  modport sink (input valid, res_seconds, res_micro, is_less, is_equal, overflow,
                output ready);
endinterface

// File: hw/rtl/sma_front.sv
module sma_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  sma_req_if.sink         request,
  output sma_pkg::front_t front
);

  logic [31:0]        cnt_mag;
  logic [51:0]        um;
  logic [20:0]        usum;
  logic               a_lt_b;
  logic signed [64:0] pp_lo;
  logic signed [63:0] pp_hi;
  logic signed [64:0] a_ext;
  logic signed [64:0] b_ext;
  sma_pkg::front_t    front_next;

  assign request.ready = adv && !rst;

  assign cnt_mag = request.scale_count[31] ? 32'(-request.scale_count)
                                           : 32'(request.scale_count);
  assign um      = 52'(request.a_micro) * 52'(cnt_mag);
  assign usum    = 21'(request.a_micro) + 21'(request.b_micro);
  assign a_lt_b  = request.a_micro < request.b_micro;

  assign pp_lo = $signed({1'b0, request.a_seconds[31:0]}) * request.scale_count;
  assign pp_hi = $signed(request.a_seconds[63:32]) * request.scale_count;
  assign a_ext = {request.a_seconds[63], request.a_seconds};
  assign b_ext = {request.b_seconds[63], request.b_seconds};

  always_comb begin
    front_next.kind   = request.kind;
    front_next.less   = (request.a_seconds < request.b_seconds) ||
                        ((request.a_seconds == request.b_seconds) && a_lt_b);
    front_next.equal  = (request.a_seconds == request.b_seconds) &&
                        (request.a_micro == request.b_micro);
    front_next.pp_lo  = pp_lo;
    front_next.pp_hi  = pp_hi;
    front_next.addsub = (request.kind == sma_pkg::KIND_SUB) ? 65'(a_ext - b_ext)
                                                            : 65'(a_ext + b_ext);
    case (request.kind)
      sma_pkg::KIND_ADD: begin
        front_next.mag = 51'(usum);
        front_next.neg = 1'b0;
      end
      sma_pkg::KIND_SUB: begin
        front_next.mag = a_lt_b ? 51'(request.b_micro - request.a_micro)
                                : 51'(request.a_micro - request.b_micro);
        front_next.neg = a_lt_b;
      end
      sma_pkg::KIND_SCALE: begin
        front_next.mag = um[50:0];
        front_next.neg = request.scale_count[31];
      end
      default: begin
        front_next.mag = '0;
        front_next.neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front <= front_next;
    end
  end

endmodule

// File: hw/rtl/sma_floor_div.sv
module sma_floor_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [50:0] mag,
  input  logic        neg,
  output logic [33:0] quot,
  output logic [19:0] rem
);

  localparam int LB = sma_pkg::LOW_BITS;

  logic [44:0]   v;
  logic [63:0]   p_lo;
  logic [44:0]   p_hi;
  logic [76:0]   prod;
  logic [15:0]   t;
  logic [15:0]   rv;
  logic [15:0]   rv_fix;
  logic          fix;
  logic [19:0]   ru;
  logic [33:0]   q_ext;

  // stage 2: partial products of the reciprocal multiply
  logic [63:0]   s2_plo;
  logic [44:0]   s2_phi;
  logic [15:0]   s2_v;
  logic [LB-1:0] s2_low;
  logic          s2_neg;
  // stage 3: quotient estimate
  logic [31:0]   s3_q;
  logic [15:0]   s3_v;
  logic [LB-1:0] s3_low;
  logic          s3_neg;
  // stage 4: corrected quotient and remainder
  logic [31:0]   s4_q;
  logic [13:0]   s4_rv;
  logic [LB-1:0] s4_low;
  logic          s4_neg;

  assign v    = mag[50:LB];
  assign p_lo = 64'(v[31:0]) * 64'(sma_pkg::RECIP);
  assign p_hi = 45'(v[44:32]) * 45'(sma_pkg::RECIP);
  assign prod = 77'(s2_plo) + {s2_phi, 32'b0};

  // remainder is below twice the divisor, so 16 low bits suffice
  assign t      = s3_q[15:0] * 16'(sma_pkg::SUB_DIVISOR);
  assign rv     = s3_v - t;
  assign fix    = rv >= 16'(sma_pkg::SUB_DIVISOR);
  assign rv_fix = rv - 16'(sma_pkg::SUB_DIVISOR);

  assign ru    = {s4_rv, s4_low};
  assign q_ext = {2'b00, s4_q};

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_plo <= p_lo;
      s2_phi <= p_hi;
      s2_v   <= v[15:0];
      s2_low <= mag[LB-1:0];
      s2_neg <= neg;

      s3_q   <= prod[76:sma_pkg::RECIP_SHIFT];
      s3_v   <= s2_v;
      s3_low <= s2_low;
      s3_neg <= s2_neg;

      s4_q   <= fix ? s3_q + 32'd1 : s3_q;
      s4_rv  <= fix ? rv_fix[13:0] : rv[13:0];
      s4_low <= s3_low;
      s4_neg <= s3_neg;

      // negative total: borrow a second when a remainder is left
      if (s4_neg && (ru != 20'd0)) begin
        quot <= ~q_ext;
        rem  <= sma_pkg::USEC_PER_SEC - ru;
      end else if (s4_neg) begin
        quot <= 34'd0 - q_ext;
        rem  <= 20'd0;
      end else begin
        quot <= q_ext;
        rem  <= ru;
      end
    end
  end

endmodule

// File: hw/rtl/sma_seconds.sv
module sma_seconds (
  input  logic            clk,
  input  logic            adv,
  input  sma_pkg::front_t front,
  output sma_pkg::sec_t   sec
);

  sma_pkg::sec_t base_next;
  sma_pkg::sec_t s2;
  sma_pkg::sec_t s3;
  sma_pkg::sec_t s4;
  logic [97:0]   hi_ext;
  logic [97:0]   lo_ext;
  logic [97:0]   as_ext;

  assign hi_ext = {{2{front.pp_hi[63]}}, front.pp_hi, 32'b0};
  assign lo_ext = {{33{front.pp_lo[64]}}, front.pp_lo};
  assign as_ext = {{33{front.addsub[64]}}, front.addsub};

  always_comb begin
    base_next.kind  = front.kind;
    base_next.less  = front.less;
    base_next.equal = front.equal;
    base_next.base  = (front.kind == sma_pkg::KIND_SCALE) ? hi_ext + lo_ext : as_ext;
  end

  // hold the seconds alongside the divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s2  <= base_next;
      s3  <= s2;
      s4  <= s3;
      sec <= s4;
    end
  end

endmodule

// File: hw/rtl/seconds_microseconds_alu.sv
// Duration arithmetic unit on seconds plus microseconds (0..999999).
//
// request channel: one transaction per operation, carrying kind (add,
// subtract, scale by scale_count, compare) and the two durations.
// response channel: one transaction per request, in order, with the
// normalized result, compare flags and the seconds overflow flag.
//
// The path from request acceptance to response valid is six register
// stages: front operand stage, four stages of the divide by one
// million (reciprocal multiply, estimate, correction, sign fix-up), and
// the final seconds add into the output register.
// Throughput is one transaction per cycle unless the response stalls.
//
// Reset clears the stage valid bits and holds request.ready low; the
// data registers are not reset.
// When the response is stalled with a result waiting, the whole
// pipeline holds and request.ready drops; nothing is lost or repeated.
// Bubbles in the pipeline still advance while the output is stalled empty.
module seconds_microseconds_alu (
  input  logic      clk,
  input  logic      rst,
  sma_req_if.sink   request,
  sma_rsp_if.source response
);

  logic            adv;
  logic [5:0]      valid;
  sma_pkg::front_t front;
  sma_pkg::sec_t   sec;
  logic [33:0]     quot;
  logic [19:0]     rem;
  logic [97:0]     total;
  logic            ovf;

  assign adv = !valid[5] || response.ready;

  sma_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .request (request),
    .front   (front)
  );

  sma_floor_div u_div (
    .clk  (clk),
    .adv  (adv),
    .mag  (front.mag),
    .neg  (front.neg),
    .quot (quot),
    .rem  (rem)
  );

  sma_seconds u_seconds (
    .clk   (clk),
    .adv   (adv),
    .front (front),
    .sec   (sec)
  );

  assign total = sec.base + {{64{quot[33]}}, quot};
  assign ovf   = total[97:63] != {35{total[63]}};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[4:0], request.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sec.kind == sma_pkg::KIND_CMP) begin
        response.res_seconds <= '0;
        response.res_micro   <= '0;
        response.overflow    <= 1'b0;
        response.is_less     <= sec.less;
        response.is_equal    <= sec.equal;
      end else begin
        response.res_seconds <= total[63:0];
        response.res_micro   <= rem;
        response.overflow    <= ovf;
        response.is_less     <= 1'b0;
        response.is_equal    <= 1'b0;
      end
    end
  end

  assign response.valid = valid[5];

endmodule
